// File: rtl/dpoc_pkg.sv
`default_nettype none
package dpoc_pkg;

   // Width of the order count and of every entry of the ways memory
   localparam int ORDER_W = 63;
   localparam logic [ORDER_W-1:0] SAT_MAX = {ORDER_W{1'b1}};

   // Result passed from the counting engine to the output stage
   typedef struct packed {
      logic               overflow;
      logic [ORDER_W-1:0] order_count;
   } result_type;

   // Saturating add; bit ORDER_W flags saturation, the low bits hold the sum
   function automatic logic [ORDER_W:0] sat_add(input logic [ORDER_W-1:0] a,
                                                input logic [ORDER_W-1:0] b);
      logic [ORDER_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ORDER_W] ? {1'b1, SAT_MAX} : s;
   endfunction

endpackage
`default_nettype wire

// File: rtl/dpoc_ram.sv
`default_nettype none
module dpoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/dpoc_sieve.sv
`default_nettype none
module dpoc_sieve #(
   parameter int MAX_N      = 1024,
   parameter int MAX_PRIMES = 172
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // prime table write port
   output      logic                                     prime_we,
   output      logic [(MAX_PRIMES > 1 ? $clog2(MAX_PRIMES) : 1)-1:0] prime_waddr,
   output      logic [$clog2(MAX_N+1)-1:0]               prime_wdata,
   // composite mark port (shares the ways memory)
   output      logic                                     mark_we,
   output      logic [$clog2(MAX_N+1)-1:0]               mark_waddr,
   output      logic                                     mark_wdata,
   output      logic [$clog2(MAX_N+1)-1:0]               mark_raddr,
   input  wire logic                                     mark_rdata,
   // status
   output      logic                                     done,
   output      logic [$clog2(MAX_PRIMES+1)-1:0]          prime_total
);

   localparam int N_W  = $clog2(MAX_N + 1);
   localparam int PA_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
   localparam int PC_W = $clog2(MAX_PRIMES + 1);

   localparam logic [2:0] SV_CLR  = 3'd0;
   localparam logic [2:0] SV_RD   = 3'd1;
   localparam logic [2:0] SV_CHK  = 3'd2;
   localparam logic [2:0] SV_MARK = 3'd3;
   localparam logic [2:0] SV_DONE = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [N_W-1:0] i_ff, i_in;
   logic [N_W:0]   j_ff, j_in;
   logic [PC_W-1:0] cnt_ff, cnt_in;
   logic [N_W:0]   j_step;
   logic [N_W:0]   i_dbl;

   assign j_step = j_ff + {1'b0, i_ff};
   assign i_dbl  = {i_ff, 1'b0};

   // Clear the marks, then walk the candidates and strike multiples of each prime
   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      cnt_in      = cnt_ff;
      prime_we    = 1'b0;
      prime_waddr = cnt_ff[PA_W-1:0];
      prime_wdata = i_ff;
      mark_we     = 1'b0;
      mark_waddr  = i_ff;
      mark_wdata  = 1'b0;
      mark_raddr  = i_ff;
      unique case (state_ff)
         SV_CLR: begin
            mark_we = 1'b1;
            if (i_ff == N_W'(MAX_N)) begin
               i_in     = N_W'(2);
               state_in = SV_RD;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         SV_RD: begin
            state_in = SV_CHK;
         end
         SV_CHK: begin
            if (!mark_rdata) begin
               prime_we = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               j_in     = i_dbl;
               if (cnt_in == PC_W'(MAX_PRIMES) || i_ff == N_W'(MAX_N)) begin
                  state_in = SV_DONE;
               end else if (i_dbl <= (N_W+1)'(MAX_N)) begin
                  state_in = SV_MARK;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = SV_RD;
               end
            end else if (i_ff == N_W'(MAX_N)) begin
               state_in = SV_DONE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = SV_RD;
            end
         end
         SV_MARK: begin
            mark_we    = 1'b1;
            mark_waddr = j_ff[N_W-1:0];
            mark_wdata = 1'b1;
            j_in       = j_step;
            if (j_step > (N_W+1)'(MAX_N)) begin
               i_in     = i_ff + 1'b1;
               state_in = SV_RD;
            end
         end
         SV_DONE: begin
            state_in = SV_DONE;
         end
         default: begin
            state_in = SV_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SV_CLR;
         i_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         cnt_ff   <= cnt_in;
      end
      j_ff <= j_in;
   end

   assign done        = (state_ff == SV_DONE);
   assign prime_total = cnt_ff;

endmodule
`default_nettype wire

// File: rtl/dpoc_count.sv
`default_nettype none
module dpoc_count #(
   parameter int MAX_N      = 1024,
   parameter int MAX_PRIMES = 172
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // request side
   input  wire logic                                     start,
   input  wire logic [$clog2(MAX_N+1)-1:0]               bound,
   output      logic                                     idle,
   // result side, held until taken
   output      logic                                     res_valid,
   input  wire logic                                     res_take,
   output      dpoc_pkg::result_type                     res,
   // prime table
   input  wire logic [$clog2(MAX_PRIMES+1)-1:0]          prime_total,
   output      logic [(MAX_PRIMES > 1 ? $clog2(MAX_PRIMES) : 1)-1:0] prime_raddr,
   input  wire logic [$clog2(MAX_N+1)-1:0]               prime_rdata,
   // ways memory
   output      logic                                     ways_we,
   output      logic [$clog2(MAX_N+1)-1:0]               ways_waddr,
   output      logic [dpoc_pkg::ORDER_W-1:0]             ways_wdata,
   output      logic [$clog2(MAX_N+1)-1:0]               ways_raddr,
   input  wire logic [dpoc_pkg::ORDER_W-1:0]             ways_rdata
);

   localparam int N_W  = $clog2(MAX_N + 1);
   localparam int PA_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
   localparam int PC_W = $clog2(MAX_PRIMES + 1);
   localparam int OW   = dpoc_pkg::ORDER_W;

   localparam logic [3:0] CT_IDLE = 4'd0;
   localparam logic [3:0] CT_CLR  = 4'd1;
   localparam logic [3:0] CT_PRD  = 4'd2;
   localparam logic [3:0] CT_PCHK = 4'd3;
   localparam logic [3:0] CT_K0   = 4'd4;
   localparam logic [3:0] CT_KL   = 4'd5;
   localparam logic [3:0] CT_SRD  = 4'd6;
   localparam logic [3:0] CT_SACC = 4'd7;
   localparam logic [3:0] CT_DONE = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic [N_W-1:0]   k_ff, k_in;
   logic [N_W-1:0]   p_ff, p_in;
   logic [2*N_W-1:0] pw_ff, pw_in;
   logic [PC_W-1:0]  pi_ff, pi_in;
   logic             first_ff, first_in;
   logic [OW-1:0]    acc_ff, acc_in;
   logic             ovf_ff, ovf_in;
   logic [OW:0]      acc_sum;
   logic [OW-1:0]    acc_new;

   assign acc_sum = dpoc_pkg::sat_add(acc_ff, ways_rdata);
   assign acc_new = first_ff ? ways_rdata : acc_sum[OW-1:0];

   // Clear the ways, fold in each prime's powers with the sum descending, then add up
   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      p_in        = p_ff;
      pw_in       = pw_ff;
      pi_in       = pi_ff;
      first_in    = first_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      prime_raddr = pi_ff[PA_W-1:0];
      ways_we     = 1'b0;
      ways_waddr  = k_ff;
      ways_wdata  = '0;
      ways_raddr  = k_ff;
      unique case (state_ff)
         CT_IDLE: begin
            if (start) begin
               n_in     = bound;
               k_in     = '0;
               ovf_in   = 1'b0;
               state_in = CT_CLR;
            end
         end
         CT_CLR: begin
            ways_we    = 1'b1;
            ways_wdata = OW'(k_ff == '0);
            pi_in      = '0;
            if (k_ff == n_ff) begin
               k_in     = '0;
               acc_in   = '0;
               state_in = (prime_total == '0) ? CT_SRD : CT_PRD;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         CT_PRD: begin
            state_in = CT_PCHK;
         end
         CT_PCHK: begin
            p_in = prime_rdata;
            if (prime_rdata > n_ff || prime_rdata < N_W'(2)) begin
               k_in     = '0;
               acc_in   = '0;
               state_in = CT_SRD;
            end else begin
               k_in     = n_ff;
               state_in = CT_K0;
            end
         end
         CT_K0: begin
            pw_in    = (2*N_W)'(p_ff);
            first_in = 1'b1;
            state_in = CT_KL;
         end
         CT_KL: begin
            first_in = 1'b0;
            acc_in   = acc_new;
            if (!first_ff && acc_sum[OW]) begin
               ovf_in = 1'b1;
            end
            if (pw_ff <= (2*N_W)'(k_ff)) begin
               ways_raddr = k_ff - pw_ff[N_W-1:0];
               pw_in      = pw_ff[N_W-1:0] * p_ff;
            end else begin
               ways_we    = 1'b1;
               ways_wdata = acc_new;
               if (k_ff == p_ff) begin
                  pi_in = pi_ff + 1'b1;
                  if (pi_in == prime_total) begin
                     k_in     = '0;
                     acc_in   = '0;
                     state_in = CT_SRD;
                  end else begin
                     state_in = CT_PRD;
                  end
               end else begin
                  k_in     = k_ff - 1'b1;
                  state_in = CT_K0;
               end
            end
         end
         CT_SRD: begin
            first_in = 1'b0;
            state_in = CT_SACC;
         end
         CT_SACC: begin
            acc_in = acc_sum[OW-1:0];
            if (acc_sum[OW]) begin
               ovf_in = 1'b1;
            end
            if (k_ff == n_ff) begin
               state_in = CT_DONE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = CT_SRD;
            end
         end
         CT_DONE: begin
            if (res_take) begin
               state_in = CT_IDLE;
            end
         end
         default: begin
            state_in = CT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CT_IDLE;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
      end
      n_ff     <= n_in;
      k_ff     <= k_in;
      p_ff     <= p_in;
      pw_ff    <= pw_in;
      pi_ff    <= pi_in;
      first_ff <= first_in;
      acc_ff   <= acc_in;
   end

   assign idle            = (state_ff == CT_IDLE);
   assign res_valid       = (state_ff == CT_DONE);
   assign res.overflow    = ovf_ff;
   assign res.order_count = acc_ff;

endmodule
`default_nettype wire

// File: rtl/distinct_permutation_order_count_unit.sv
// Channel | Dir | Signals                      | Contents
// req     | in  | req_tvalid/tready/tdata[15:0] | bound_n
// rsp     | out | rsp_tvalid/tready/tdata[63:0] | order_count, tuser = overflow
//
// After reset a sieve clears the ways memory and fills the prime table;
// req_tready stays low meanwhile. A request of bound n clears the ways, folds
// in the powers of every prime p <= n at each sum k = n..p, then sums the
// ways; the single ways memory port pair paces this work.
// One request is worked at a time; the next is taken while a result waits
// in the output register, and a stalled output holds the engine at its end.
`default_nettype none
module distinct_permutation_order_count_unit #(
   parameter int MAX_N      = 1024,
   parameter int MAX_PRIMES = 172
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [10:0] bound_n
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [62:0] order_count
   output      logic        rsp_tuser    // [0] overflow
);

   localparam int N_W  = $clog2(MAX_N + 1);
   localparam int PA_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
   localparam int PC_W = $clog2(MAX_PRIMES + 1);
   localparam int OW   = dpoc_pkg::ORDER_W;

   logic                 sieve_done;
   logic [PC_W-1:0]      prime_total;
   logic                 prime_we;
   logic [PA_W-1:0]      prime_waddr;
   logic [N_W-1:0]       prime_wdata;
   logic [PA_W-1:0]      prime_raddr;
   logic [N_W-1:0]       prime_rdata;
   logic                 mark_we;
   logic [N_W-1:0]       mark_waddr;
   logic                 mark_wdata;
   logic [N_W-1:0]       mark_raddr;
   logic                 cnt_we;
   logic [N_W-1:0]       cnt_waddr;
   logic [OW-1:0]        cnt_wdata;
   logic [N_W-1:0]       cnt_raddr;
   logic                 ways_we;
   logic [N_W-1:0]       ways_waddr;
   logic [OW-1:0]        ways_wdata;
   logic [N_W-1:0]       ways_raddr;
   logic [OW-1:0]        ways_rdata;
   logic                 eng_idle;
   logic                 res_valid;
   logic                 res_take;
   dpoc_pkg::result_type res;
   logic [N_W-1:0]       bound_clip;
   logic                 rsp_valid_ff, rsp_valid_in;
   dpoc_pkg::result_type rsp_res_ff;

   // Limit the bound to the table size
   always_comb begin
      if (int'(req_tdata[10:0]) > MAX_N) begin
         bound_clip = N_W'(MAX_N);
      end else begin
         bound_clip = N_W'(req_tdata[10:0]);
      end
   end

   assign req_tready = sieve_done && eng_idle;

   dpoc_sieve #(
      .MAX_N      (MAX_N),
      .MAX_PRIMES (MAX_PRIMES)
   ) u_sieve (
      .clock       (clock),
      .reset       (reset),
      .prime_we    (prime_we),
      .prime_waddr (prime_waddr),
      .prime_wdata (prime_wdata),
      .mark_we     (mark_we),
      .mark_waddr  (mark_waddr),
      .mark_wdata  (mark_wdata),
      .mark_raddr  (mark_raddr),
      .mark_rdata  (ways_rdata[0]),
      .done        (sieve_done),
      .prime_total (prime_total)
   );

   dpoc_count #(
      .MAX_N      (MAX_N),
      .MAX_PRIMES (MAX_PRIMES)
   ) u_count (
      .clock       (clock),
      .reset       (reset),
      .start       (req_tvalid && req_tready),
      .bound       (bound_clip),
      .idle        (eng_idle),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res         (res),
      .prime_total (prime_total),
      .prime_raddr (prime_raddr),
      .prime_rdata (prime_rdata),
      .ways_we     (cnt_we),
      .ways_waddr  (cnt_waddr),
      .ways_wdata  (cnt_wdata),
      .ways_raddr  (cnt_raddr),
      .ways_rdata  (ways_rdata)
   );

   // Hand the ways memory to the sieve until it finishes
   always_comb begin
      if (sieve_done) begin
         ways_we    = cnt_we;
         ways_waddr = cnt_waddr;
         ways_wdata = cnt_wdata;
         ways_raddr = cnt_raddr;
      end else begin
         ways_we    = mark_we;
         ways_waddr = mark_waddr;
         ways_wdata = OW'(mark_wdata);
         ways_raddr = mark_raddr;
      end
   end

   dpoc_ram #(
      .WIDTH (N_W),
      .DEPTH (MAX_PRIMES)
   ) u_prime_ram (
      .clock   (clock),
      .wr_en   (prime_we),
      .wr_addr (prime_waddr),
      .wr_data (prime_wdata),
      .rd_addr (prime_raddr),
      .rd_data (prime_rdata)
   );

   dpoc_ram #(
      .WIDTH (OW),
      .DEPTH (MAX_N + 1)
   ) u_ways_ram (
      .clock   (clock),
      .wr_en   (ways_we),
      .wr_addr (ways_waddr),
      .wr_data (ways_wdata),
      .rd_addr (ways_raddr),
      .rd_data (ways_rdata)
   );

   // Move a finished result into the output register when it is free
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_res_ff.order_count};
   assign rsp_tuser  = rsp_res_ff.overflow;

endmodule
`default_nettype wire

// File: dv/distinct_permutation_order_count_unit_tb.sv
`default_nettype none
module distinct_permutation_order_count_unit_tb;

   localparam int MAX_BOUND  = 1024;
   localparam int PRIME_SLOTS = 172;
   // Cycles with no transfer on either side before the run is abandoned
   localparam int unsigned IDLE_LIMIT = 1_500_000;
   // Receiver hold-off used to fill the block and stall its input
   localparam int unsigned LONG_HOLD = 3000;
   // Quiet cycles after the last result to catch stray transfers
   localparam int unsigned SETTLE_CYCLES = 2000;
   localparam logic [63:0] COUNT_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [10:0] bound_n
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [62:0] order_count
   logic        rsp_tuser;        // [0] overflow

   // Expected results in transfer order
   dpoc_pkg::result_type order_expected[$];
   int unsigned mismatch_count = 0;

   // Predictor state: primes up to the largest bound and the ways-by-sum table
   int unsigned prime_list[$];
   logic [63:0] ways_by_total [0:MAX_BOUND];

   // Idling controls and receiver hold-off bookkeeping
   logic        sender_gaps = 1'b1;
   logic        sink_gaps = 1'b1;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned sink_wait = 0;
   int unsigned idle_cycles = 0;

   distinct_permutation_order_count_unit #(
      .MAX_N     (MAX_BOUND),
      .MAX_PRIMES(PRIME_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Saturating add at 2^63-1; bit 64 flags saturation
   function automatic logic [64:0] add_capped(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] s;
      x = (a > COUNT_CAP) ? COUNT_CAP : a;
      y = (b > COUNT_CAP) ? COUNT_CAP : b;
      s = x + y;
      if (s > COUNT_CAP)
         return {1'b1, COUNT_CAP};
      return {1'b0, s};
   endfunction

   // Count distinct cycle-length LCMs with sum <= bound by a grouped knapsack
   // over prime powers, sum index descending
   function automatic dpoc_pkg::result_type predict_order_count(input logic [10:0] bound);
      int unsigned n;
      int unsigned k;
      int unsigned p;
      int unsigned pw;
      logic [63:0] acc;
      logic [63:0] total;
      logic [64:0] r;
      logic        sat;
      dpoc_pkg::result_type res;
      n = (bound > MAX_BOUND) ? MAX_BOUND : bound;
      for (k = 0; k <= n; k++)
         ways_by_total[k] = '0;
      ways_by_total[0] = 64'd1;
      sat = 1'b0;
      foreach (prime_list[i]) begin
         p = prime_list[i];
         if (p > n)
            break;
         for (k = n; k >= p; k--) begin
            acc = ways_by_total[k];
            for (pw = p; pw <= k; pw = pw * p) begin
               r = add_capped(acc, ways_by_total[k - pw]);
               acc = r[63:0];
               sat = sat | r[64];
            end
            ways_by_total[k] = acc;
         end
      end
      total = '0;
      for (k = 0; k <= n; k++) begin
         r = add_capped(total, ways_by_total[k]);
         total = r[63:0];
         sat = sat | r[64];
      end
      res.order_count = total[dpoc_pkg::ORDER_W-1:0];
      res.overflow = sat;
      return res;
   endfunction

   // Compare one result transfer with the oldest expectation
   task automatic check_order_result(input logic [63:0] data, input logic flag);
      dpoc_pkg::result_type want;
      if (order_expected.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: count %0d overflow %0b", data, flag);
      end else begin
         want = order_expected.pop_front();
         if (data !== {1'b0, want.order_count} || flag !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result mismatch: expected count %0d overflow %0b, got count %0d overflow %0b",
                        want.order_count, want.overflow, data, flag);
         end
      end
   endtask

   // Receiver: check each transfer, stall per item, honor long hold-off requests
   always @(posedge clock) begin : sink_side
      int unsigned stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait <= 0;
         hold_left <= 0;
         holds_served <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_order_result(rsp_tdata, rsp_tuser);
         if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= (hold_left == 1);
         end else if (rsp_tvalid && rsp_tready) begin
            stall = sink_gaps ? $urandom_range(0, 3) : 0;
            sink_wait <= stall;
            rsp_tready <= (stall == 0);
         end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            rsp_tready <= (sink_wait == 1);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Abort when neither side transfers for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one bound after a random gap and hold it until transferred
   task automatic send_bound(input logic [10:0] bound);
      dpoc_pkg::result_type want;
      int unsigned gap;
      want = predict_order_count(bound);
      gap = sender_gaps ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, bound};
      do @(posedge clock); while (!req_tready);
      order_expected.push_back(want);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (order_expected.size() != 0)
         @(posedge clock);
   endtask

   // Mostly cheap bounds, now and then a mid-size one
   function automatic logic [10:0] draw_bound();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return 11'($urandom_range(0, 40));
      if (pick < 95)
         return 11'($urandom_range(41, 120));
      return 11'($urandom_range(121, 250));
   endfunction

   // Trivial bounds, small bounds, the table limit and the all-ones bound
   task automatic test_extreme_bounds();
      logic [10:0] bounds[$];
      bounds = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd7, 11'd11, 11'd16,
                 11'd30, 11'd64, 11'd100, 11'd1024, 11'd2047};
      foreach (bounds[i])
         send_bound(bounds[i]);
      drain_results();
   endtask

   // Hold the receiver off while the sender keeps offering back to back
   task automatic test_input_backpressure();
      sender_gaps = 1'b0;
      hold_requests <= hold_requests + 1;
      repeat (8)
         send_bound(11'($urandom_range(0, 20)));
      sender_gaps = 1'b1;
      drain_results();
   endtask

   // Pause the sender until everything outstanding has come back
   task automatic test_sender_pause();
      repeat (3)
         send_bound(draw_bound());
      drain_results();
      repeat (3)
         send_bound(draw_bound());
      drain_results();
   endtask

   // Random bounds, with one stretch where neither side idles
   task automatic test_random_bounds();
      for (int unsigned i = 0; i < 72; i++) begin
         if (i == 40) begin
            sender_gaps = 1'b0;
            sink_gaps <= 1'b0;
         end else if (i == 60) begin
            sender_gaps = 1'b1;
            sink_gaps <= 1'b1;
         end
         send_bound(draw_bound());
      end
      drain_results();
   endtask

   initial begin
      // Primes up to the largest bound, ascending
      for (int unsigned c = 2; c <= MAX_BOUND; c++) begin
         automatic bit is_prime = 1'b1;
         foreach (prime_list[i])
            if (c % prime_list[i] == 0)
               is_prime = 1'b0;
         if (is_prime && prime_list.size() < PRIME_SLOTS)
            prime_list.push_back(c);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_extreme_bounds();
      test_input_backpressure();
      test_sender_pause();
      test_random_bounds();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && order_expected.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
